// ----- rtl/core/pic_pkg.sv -----
// Shared types, command codes and the priority resolver of the interrupt controller.
// No dependencies; imported by the input register, the core and the top level.
`default_nettype none

package pic_pkg;

    // Operation carried by one input transfer
    typedef enum logic [1:0] {
        OP_WRITE  = 2'd0,
        OP_READ   = 2'd1,
        OP_SAMPLE = 2'd2,
        OP_ACK    = 2'd3
    } pic_op_t;

    // Initialisation sequence position
    typedef enum logic [1:0] {
        PH_READY = 2'd0,
        PH_ICW2  = 2'd1,
        PH_ICW3  = 2'd2,
        PH_ICW4  = 2'd3
    } pic_phase_t;

    // Command byte bit positions on port 0
    localparam int unsigned ICW1_BIT     = 4;   // initialisation start
    localparam int unsigned OCW3_BIT     = 3;   // read select command
    localparam int unsigned EOI_BIT      = 5;   // end of interrupt
    localparam int unsigned SL_BIT       = 6;   // specific level
    localparam int unsigned RR_BIT       = 1;   // read register enable
    localparam int unsigned RIS_BIT      = 0;   // ISR/IRR select
    localparam int unsigned LTIM_BIT     = 3;   // level-triggered mode
    localparam int unsigned SNGL_BIT     = 1;   // single mode
    localparam int unsigned IC4_BIT      = 0;   // ICW4 follows
    localparam int unsigned AEOI_BIT     = 1;   // auto-EOI in ICW4

    localparam logic [2:0] SPURIOUS_LEVEL = 3'd7;
    localparam logic [3:0] NO_LEVEL       = 4'd8;

    // One registered input item
    typedef struct packed {
        pic_op_t    opcode;
        logic       port_select;
        logic [7:0] write_data;
        logic [7:0] line_levels;
    } pic_item_t;

    // Return the lowest set bit index (IR0 highest priority), or NO_LEVEL
    function automatic logic [3:0] top_level(input logic [7:0] bits);
        logic [3:0] lvl;
        lvl = NO_LEVEL;
        for (int i = 7; i >= 0; i--) begin
            if (bits[i]) begin
                lvl = 4'(i);
            end
        end
        return lvl;
    endfunction

    // Winning level given request, mask and in-service, or NO_LEVEL
    function automatic logic [3:0] winner(input logic [7:0] irr, input logic [7:0] imr,
                                          input logic [7:0] isr);
        logic [3:0] req;
        logic [3:0] svc;
        req = top_level(irr & ~imr);
        svc = top_level(isr);
        return (req < svc) ? req : NO_LEVEL;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/core/pic_in_stage.sv -----
// Input register of the interrupt controller: holds one accepted transfer.
// Depends on pic_pkg for the item type.
`default_nettype none

module pic_in_stage (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire pic_pkg::pic_item_t s_item,
    input  wire logic              advance,
    output logic                   item_valid,
    output pic_pkg::pic_item_t     item
);
    import pic_pkg::*;

    logic      valid_reg;
    logic      valid_next;
    pic_item_t item_reg;

    // Take a new transfer when empty or when the held one moves on
    assign s_ready    = !valid_reg || advance;
    assign valid_next = s_ready ? s_valid : valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // Capture payload on each accepted transfer
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg <= s_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

`default_nettype wire

// ----- rtl/core/pic_core.sv -----
// Controller state, command decode, priority resolution and the result register.
// Depends on pic_pkg for types, command bit positions and the priority functions.
`default_nettype none

module pic_core (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               item_valid,
    input  wire pic_pkg::pic_item_t item,
    output logic                    advance,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic [7:0]              m_read_data,
    output logic                    m_interrupt_out,
    output logic                    m_spurious
);
    import pic_pkg::*;

    pic_phase_t phase_reg, phase_next;
    logic [4:0] base_reg, base_next;
    logic       level_mode_reg, level_mode_next;
    logic       single_reg, single_next;
    logic       icw4_reg, icw4_next;
    logic       aeoi_reg, aeoi_next;
    logic [7:0] irr_reg, irr_next;
    logic [7:0] isr_reg, isr_next;
    logic [7:0] imr_reg, imr_next;
    logic       ris_reg, ris_next;
    logic [7:0] last_reg, last_next;

    logic       out_valid_reg, out_valid_next;
    logic [7:0] rd_reg, rd_next;
    logic       int_reg, int_next;
    logic       spur_reg, spur_next;

    logic [3:0] win_now;
    logic [3:0] top_svc;
    logic [3:0] win_after;

    // Move the held item into the result register when it is free or being taken
    assign advance        = item_valid && (!out_valid_reg || m_ready);
    assign out_valid_next = advance || (out_valid_reg && !m_ready);

    assign win_now = winner(irr_reg, imr_reg, isr_reg);
    assign top_svc = top_level(isr_reg);

    // Work out the state after the item and its result
    always_comb begin
        phase_next      = phase_reg;
        base_next       = base_reg;
        level_mode_next = level_mode_reg;
        single_next     = single_reg;
        icw4_next       = icw4_reg;
        aeoi_next       = aeoi_reg;
        irr_next        = irr_reg;
        isr_next        = isr_reg;
        imr_next        = imr_reg;
        ris_next        = ris_reg;
        last_next       = last_reg;
        rd_next         = 8'd0;
        spur_next       = 1'b0;

        case (item.opcode)
            OP_WRITE: begin
                if (item.port_select) begin
                    case (phase_reg)
                        PH_ICW2: begin
                            base_next = item.write_data[7:3];
                            if (!single_reg) begin
                                phase_next = PH_ICW3;
                            end else begin
                                phase_next = icw4_reg ? PH_ICW4 : PH_READY;
                            end
                        end
                        PH_ICW3: begin
                            phase_next = icw4_reg ? PH_ICW4 : PH_READY;
                        end
                        PH_ICW4: begin
                            aeoi_next  = item.write_data[AEOI_BIT];
                            phase_next = PH_READY;
                        end
                        default: begin
                            imr_next = item.write_data;
                        end
                    endcase
                end else if (item.write_data[ICW1_BIT]) begin
                    level_mode_next = item.write_data[LTIM_BIT];
                    single_next     = item.write_data[SNGL_BIT];
                    icw4_next       = item.write_data[IC4_BIT];
                    if (!item.write_data[IC4_BIT]) begin
                        aeoi_next = 1'b0;
                    end
                    imr_next   = 8'd0;
                    ris_next   = 1'b0;
                    phase_next = PH_ICW2;
                end else if (item.write_data[OCW3_BIT]) begin
                    if (item.write_data[RR_BIT]) begin
                        ris_next = item.write_data[RIS_BIT];
                    end
                end else if (item.write_data[EOI_BIT]) begin
                    if (item.write_data[SL_BIT]) begin
                        isr_next = isr_reg & ~(8'd1 << item.write_data[2:0]);
                    end else if (!top_svc[3]) begin
                        isr_next = isr_reg & ~(8'd1 << top_svc[2:0]);
                    end
                end
            end
            OP_READ: begin
                if (item.port_select) begin
                    rd_next = imr_reg;
                end else begin
                    rd_next = ris_reg ? isr_reg : irr_reg;
                end
            end
            OP_SAMPLE: begin
                if (level_mode_reg) begin
                    irr_next = item.line_levels;
                end else begin
                    irr_next = irr_reg | (item.line_levels & ~last_reg);
                end
                last_next = item.line_levels;
            end
            default: begin
                // Acknowledge: hand out the winning level or a spurious level 7
                if (!win_now[3]) begin
                    irr_next = irr_reg & ~(8'd1 << win_now[2:0]);
                    if (!aeoi_reg) begin
                        isr_next = isr_reg | (8'd1 << win_now[2:0]);
                    end
                    rd_next = {base_reg, win_now[2:0]};
                end else begin
                    spur_next = 1'b1;
                    rd_next   = {base_reg, SPURIOUS_LEVEL};
                end
            end
        endcase
    end

    assign win_after = winner(irr_next, imr_next, isr_next);
    assign int_next  = !win_after[3];

    // Hold controller state; update only when an item completes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= PH_READY;
            base_reg       <= 5'd0;
            level_mode_reg <= 1'b0;
            single_reg     <= 1'b1;
            icw4_reg       <= 1'b0;
            aeoi_reg       <= 1'b0;
            irr_reg        <= 8'd0;
            isr_reg        <= 8'd0;
            imr_reg        <= 8'd0;
            ris_reg        <= 1'b0;
            last_reg       <= 8'd0;
            out_valid_reg  <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
            if (advance) begin
                phase_reg      <= phase_next;
                base_reg       <= base_next;
                level_mode_reg <= level_mode_next;
                single_reg     <= single_next;
                icw4_reg       <= icw4_next;
                aeoi_reg       <= aeoi_next;
                irr_reg        <= irr_next;
                isr_reg        <= isr_next;
                imr_reg        <= imr_next;
                ris_reg        <= ris_next;
                last_reg       <= last_next;
            end
        end
    end

    // Load the result payload on each completed item
    always_ff @(posedge aclk) begin
        if (advance) begin
            rd_reg   <= rd_next;
            int_reg  <= int_next;
            spur_reg <= spur_next;
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_read_data     = rd_reg;
    assign m_interrupt_out = int_reg;
    assign m_spurious      = spur_reg;

endmodule

`default_nettype wire

// ----- rtl/core/programmable_interrupt_controller_unit.sv -----
// Top level of the eight-line interrupt controller: input register and core.
// Depends on pic_pkg, pic_in_stage and pic_core.
//
// Usage:
//   The s_ channel carries one bus access, line sample or acknowledge per
//   transfer (opcode, port_select, write_data, line_levels). The m_ channel
//   returns exactly one result per input transfer: read_data, interrupt_out
//   (request pending above every in-service level after the item) and
//   spurious (acknowledge with no winner).
//   A result reaches m_valid through two registers: the input register, then
//   the decode and 8-bit priority logic into the result register. Throughput
//   is one item per cycle while m_ready stays high, set by the single pass
//   through the priority logic between those two registers.
//   While the receiver stalls, the result register holds its item and the
//   input register still takes one more transfer; s_ready then drops until
//   m_ready returns.
//   Reset (aresetn low, synchronous) empties both registers and returns the
//   controller to its power-up state: ready, edge mode, single mode, all of
//   IRR, ISR and mask clear.
`default_nettype none

module programmable_interrupt_controller_unit (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic [1:0] s_opcode,
    input  wire logic       s_port_select,
    input  wire logic [7:0] s_write_data,
    input  wire logic [7:0] s_line_levels,
    output logic            m_valid,
    input  wire logic       m_ready,
    output logic [7:0]      m_read_data,
    output logic            m_interrupt_out,
    output logic            m_spurious
);
    import pic_pkg::*;

    pic_item_t s_item;
    pic_item_t item;
    logic      item_valid;
    logic      advance;

    // Pack the input ports into one item
    assign s_item.opcode      = pic_op_t'(s_opcode);
    assign s_item.port_select = s_port_select;
    assign s_item.write_data  = s_write_data;
    assign s_item.line_levels = s_line_levels;

    pic_in_stage u_in_stage (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_item     (s_item),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    pic_core u_core (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .item_valid      (item_valid),
        .item            (item),
        .advance         (advance),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_read_data     (m_read_data),
        .m_interrupt_out (m_interrupt_out),
        .m_spurious      (m_spurious)
    );

endmodule

`default_nettype wire

// ----- rtl/core/pic_checker.sv -----
// Port-level checks of the interrupt controller, bound to the top level.
// Depends only on the ports of programmable_interrupt_controller_unit.
`default_nettype none

module pic_checker (
    input wire logic       aclk,
    input wire logic       aresetn,
    input wire logic       s_valid,
    input wire logic       s_ready,
    input wire logic       m_valid,
    input wire logic       m_ready,
    input wire logic [7:0] m_read_data,
    input wire logic       m_spurious
);

    // Hold a stalled result until its transfer
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("result dropped while stalled");

    // Come out of reset with no result pending
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result pending after reset");

    // Always take input while the result register is empty
    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input refused with empty result register");

    // A spurious acknowledge returns level 7
    a_spurious_level: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_spurious |-> m_read_data[2:0] == 3'd7)
        else $error("spurious vector without level 7");

    // An input transfer into an empty pipe shows a result once it has passed the input and result registers
    a_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && !m_valid ##1 !m_valid |=> m_valid)
        else $error("result missing after transfer");

endmodule

bind programmable_interrupt_controller_unit pic_checker u_pic_checker (
    .aclk        (aclk),
    .aresetn     (aresetn),
    .s_valid     (s_valid),
    .s_ready     (s_ready),
    .m_valid     (m_valid),
    .m_ready     (m_ready),
    .m_read_data (m_read_data),
    .m_spurious  (m_spurious)
);

`default_nettype wire

// ----- sim/tb_programmable_interrupt_controller_unit.sv -----
// Self-checking testbench for the eight-line interrupt controller unit.
// Depends on pic_pkg and programmable_interrupt_controller_unit; a scoreboard class
// predicts every response while plain tasks drive bus accesses, samples and acknowledges.
`timescale 1ns / 100ps

import pic_pkg::*;

// One response of the controller as seen on the m_ channel
typedef struct packed {
    logic [7:0] read_data;
    logic       interrupt_out;
    logic       spurious;
} pic_response_t;

// Tracks the controller state, predicts each response and checks the actual ones
class pic_response_model;
    pic_phase_t    phase;
    logic [4:0]    vec_base;
    logic          level_trig;
    logic          single_chip;
    logic          want_icw4;
    logic          auto_eoi;
    logic          isr_selected;
    logic [7:0]    irr;
    logic [7:0]    isr;
    logic [7:0]    imr;
    logic [7:0]    prev_lines;
    pic_response_t expected_q[$];
    int unsigned   errors;

    function new();
        phase        = PH_READY;
        vec_base     = '0;
        level_trig   = 1'b0;
        single_chip  = 1'b1;
        want_icw4    = 1'b0;
        auto_eoi     = 1'b0;
        isr_selected = 1'b0;
        irr          = '0;
        isr          = '0;
        imr          = '0;
        prev_lines   = '0;
        errors       = 0;
    endfunction

    // Index of the highest-priority set bit, IR0 first, or NO_LEVEL when clear
    function logic [3:0] first_set(logic [7:0] v);
        casez (v)
            8'b???????1: return 4'd0;
            8'b??????10: return 4'd1;
            8'b?????100: return 4'd2;
            8'b????1000: return 4'd3;
            8'b???10000: return 4'd4;
            8'b??100000: return 4'd5;
            8'b?1000000: return 4'd6;
            8'b10000000: return 4'd7;
            default:     return NO_LEVEL;
        endcase
    endfunction

    // Level that an acknowledge would take now, or NO_LEVEL
    function logic [3:0] pending_level();
        logic [3:0] req;
        logic [3:0] svc;
        req = first_set(irr & ~imr);
        svc = first_set(isr);
        return (req < svc) ? req : NO_LEVEL;
    endfunction

    // Advance the predicted state by one accepted input transfer
    function void note_access(pic_op_t op, logic port, logic [7:0] wd, logic [7:0] lv);
        pic_response_t rsp;
        logic [3:0]    lvl;
        rsp = '0;
        case (op)
            OP_WRITE: begin
                if (port) begin
                    case (phase)
                        PH_ICW2: begin
                            vec_base = wd[7:3];
                            if (!single_chip) begin
                                phase = PH_ICW3;
                            end else begin
                                phase = want_icw4 ? PH_ICW4 : PH_READY;
                            end
                        end
                        PH_ICW3: phase = want_icw4 ? PH_ICW4 : PH_READY;
                        PH_ICW4: begin
                            auto_eoi = wd[AEOI_BIT];
                            phase    = PH_READY;
                        end
                        default: imr = wd;
                    endcase
                end else if (wd[ICW1_BIT]) begin
                    level_trig   = wd[LTIM_BIT];
                    single_chip  = wd[SNGL_BIT];
                    want_icw4    = wd[IC4_BIT];
                    if (!want_icw4) begin
                        auto_eoi = 1'b0;
                    end
                    imr          = '0;
                    isr_selected = 1'b0;
                    phase        = PH_ICW2;
                end else if (wd[OCW3_BIT]) begin
                    if (wd[RR_BIT]) begin
                        isr_selected = wd[RIS_BIT];
                    end
                end else if (wd[EOI_BIT]) begin
                    if (wd[SL_BIT]) begin
                        isr[wd[2:0]] = 1'b0;
                    end else begin
                        lvl = first_set(isr);
                        if (lvl != NO_LEVEL) begin
                            isr[lvl[2:0]] = 1'b0;
                        end
                    end
                end
            end
            OP_READ: begin
                if (port) begin
                    rsp.read_data = imr;
                end else begin
                    rsp.read_data = isr_selected ? isr : irr;
                end
            end
            OP_SAMPLE: begin
                if (level_trig) begin
                    irr = lv;
                end else begin
                    irr = irr | (lv & ~prev_lines);
                end
                prev_lines = lv;
            end
            default: begin
                lvl = pending_level();
                if (lvl != NO_LEVEL) begin
                    irr[lvl[2:0]] = 1'b0;
                    if (!auto_eoi) begin
                        isr[lvl[2:0]] = 1'b1;
                    end
                    rsp.read_data = {vec_base, lvl[2:0]};
                end else begin
                    rsp.spurious  = 1'b1;
                    rsp.read_data = {vec_base, SPURIOUS_LEVEL};
                end
            end
        endcase
        rsp.interrupt_out = (pending_level() != NO_LEVEL);
        expected_q.push_back(rsp);
    endfunction

    // Compare one accepted response with the oldest prediction
    function void check_response(logic [7:0] rd, logic irq, logic spur);
        pic_response_t exp_rsp;
        if (expected_q.size() == 0) begin
            $display("%0t: unexpected response read_data %02h interrupt_out %0b spurious %0b",
                     $time, rd, irq, spur);
            errors++;
            return;
        end
        exp_rsp = expected_q.pop_front();
        if (rd !== exp_rsp.read_data) begin
            $display("%0t: read_data expected %02h, actual %02h",
                     $time, exp_rsp.read_data, rd);
            errors++;
        end
        if (irq !== exp_rsp.interrupt_out) begin
            $display("%0t: interrupt_out expected %0b, actual %0b",
                     $time, exp_rsp.interrupt_out, irq);
            errors++;
        end
        if (spur !== exp_rsp.spurious) begin
            $display("%0t: spurious expected %0b, actual %0b",
                     $time, exp_rsp.spurious, spur);
            errors++;
        end
    endfunction

    function int unsigned outstanding();
        return expected_q.size();
    endfunction
endclass

module tb_programmable_interrupt_controller_unit;

    localparam int unsigned CYCLE_LIMIT = 100000;

    logic       aclk            = 1'b0;
    logic       aresetn         = 1'b0;
    logic       s_valid         = 1'b0;
    logic       s_ready;
    logic [1:0] s_opcode        = OP_WRITE;
    logic       s_port_select   = 1'b0;
    logic [7:0] s_write_data    = 8'h00;
    logic [7:0] s_line_levels   = 8'h00;
    logic       m_valid;
    logic       m_ready         = 1'b0;
    logic [7:0] m_read_data;
    logic       m_interrupt_out;
    logic       m_spurious;

    pic_response_model model = new();

    int unsigned cycle_count        = 0;
    int unsigned items_sent         = 0;
    int unsigned sender_idle_pct    = 0;
    int unsigned receiver_stall_pct = 0;
    int unsigned hold_off_len       = 0;
    int unsigned hold_off_requests  = 0;
    int unsigned hold_off_served    = 0;
    int unsigned hold_left          = 0;
    logic [7:0]  lines_now          = 8'h00;

    programmable_interrupt_controller_unit uut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_opcode        (s_opcode),
        .s_port_select   (s_port_select),
        .s_write_data    (s_write_data),
        .s_line_levels   (s_line_levels),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_read_data     (m_read_data),
        .m_interrupt_out (m_interrupt_out),
        .m_spurious      (m_spurious)
    );

    // Generate a 4 ns clock
    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // Count cycles for the watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
    end

    // End the run with mismatches once the cycle count reaches CYCLE_LIMIT
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
        end
        $display("end of test: mismatches");
        $finish;
    end

    // Drive m_ready: random stalls, or a long hold-off when one is requested
    always @(posedge aclk) begin
        if (hold_off_served != hold_off_requests) begin
            hold_off_served = hold_off_requests;
            hold_left       = hold_off_len;
        end
        if (hold_left != 0) begin
            m_ready <= 1'b0;
            hold_left = hold_left - 1;
        end else begin
            m_ready <= ($urandom_range(99) >= receiver_stall_pct);
        end
    end

    // Note every input transfer and check every result transfer
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) begin
                model.check_response(m_read_data, m_interrupt_out, m_spurious);
            end
            if (s_valid && s_ready) begin
                model.note_access(pic_op_t'(s_opcode), s_port_select, s_write_data,
                                  s_line_levels);
            end
        end
    end

    function automatic logic [7:0] rand_byte();
        return 8'($urandom);
    endfunction

    // Offer one item, idling first at random, and hold it until transferred
    task automatic send_access(input pic_op_t op, input logic port, input logic [7:0] wd,
                               input logic [7:0] lv);
        while ($urandom_range(99) < sender_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_opcode      <= op;
        s_port_select <= port;
        s_write_data  <= wd;
        s_line_levels <= lv;
        @(posedge aclk);
        while (!s_ready) begin
            @(posedge aclk);
        end
        items_sent++;
    endtask

    // Stop offering and wait until every predicted response has arrived
    task automatic wait_for_responses();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (model.outstanding() != 0) begin
            @(posedge aclk);
        end
    endtask

    // One operational access: samples, acknowledges, EOIs, OCW3, reads, masks, noise
    task automatic send_random_operation();
        int unsigned pick;
        logic [7:0]  d;
        pick = $urandom_range(99);
        d    = rand_byte();
        if (pick < 30) begin
            if ($urandom_range(3) == 0) begin
                lines_now = rand_byte();
            end else begin
                lines_now = lines_now ^ (rand_byte() & rand_byte() & rand_byte());
            end
            send_access(OP_SAMPLE, 1'($urandom), d, lines_now);
        end else if (pick < 55) begin
            send_access(OP_ACK, 1'($urandom), d, rand_byte());
        end else if (pick < 70) begin
            d[ICW1_BIT] = 1'b0;
            d[OCW3_BIT] = 1'b0;
            if ($urandom_range(7) != 0) begin
                d[EOI_BIT] = 1'b1;
            end
            send_access(OP_WRITE, 1'b0, d, rand_byte());
        end else if (pick < 80) begin
            d[ICW1_BIT] = 1'b0;
            d[OCW3_BIT] = 1'b1;
            send_access(OP_WRITE, 1'b0, d, rand_byte());
        end else if (pick < 90) begin
            send_access(OP_READ, 1'($urandom), d, rand_byte());
        end else if (pick < 97) begin
            send_access(OP_WRITE, 1'b1, d & rand_byte() & rand_byte(), rand_byte());
        end else begin
            send_access(OP_WRITE, 1'($urandom), d, rand_byte());
        end
    endtask

    // Slip a few stray accesses into a broken init sequence
    task automatic maybe_interrupt_init(input logic broken);
        if (broken && $urandom_range(1) == 1) begin
            repeat ($urandom_range(1, 3)) begin
                send_random_operation();
            end
        end
    endtask

    // Full init sequence with random content; a quarter of them are broken and may get stray accesses
    task automatic send_init_sequence();
        logic [7:0] icw1;
        logic       broken;
        icw1           = rand_byte();
        icw1[ICW1_BIT] = 1'b1;
        broken         = ($urandom_range(99) < 25);
        send_access(OP_WRITE, 1'b0, icw1, rand_byte());
        maybe_interrupt_init(broken);
        send_access(OP_WRITE, 1'b1, rand_byte(), rand_byte());
        if (!icw1[SNGL_BIT]) begin
            maybe_interrupt_init(broken);
            send_access(OP_WRITE, 1'b1, rand_byte(), rand_byte());
        end
        if (icw1[IC4_BIT]) begin
            maybe_interrupt_init(broken);
            send_access(OP_WRITE, 1'b1, rand_byte(), rand_byte());
        end
    endtask

    task automatic run_random_accesses(input int unsigned count);
        int unsigned stop_at;
        stop_at = items_sent + count;
        while (items_sent < stop_at) begin
            if ($urandom_range(99) < 8) begin
                send_init_sequence();
            end else begin
                send_random_operation();
            end
        end
    endtask

    task automatic set_idling(input int unsigned sender_pct, input int unsigned receiver_pct);
        sender_idle_pct    = sender_pct;
        receiver_stall_pct = receiver_pct;
    endtask

    // Stimulus sequence
    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed accesses, no idling
        set_idling(0, 0);
        send_access(OP_READ,   1'b0, rand_byte(), rand_byte());
        send_access(OP_ACK,    1'b0, rand_byte(), rand_byte());   // nothing pending at reset
        send_access(OP_SAMPLE, 1'b0, rand_byte(), 8'h01);
        send_access(OP_WRITE,  1'b0, 8'h13, rand_byte());         // edge, single, ICW4
        send_access(OP_WRITE,  1'b0, 8'h0B, rand_byte());         // OCW3 inside init
        send_access(OP_WRITE,  1'b1, 8'hF8, rand_byte());         // highest vector base
        send_access(OP_WRITE,  1'b1, 8'h01, rand_byte());         // ICW4 without auto-EOI
        send_access(OP_SAMPLE, 1'b1, rand_byte(), 8'hFF);
        send_access(OP_READ,   1'b0, rand_byte(), rand_byte());
        send_access(OP_ACK,    1'b1, rand_byte(), rand_byte());
        send_access(OP_ACK,    1'b0, rand_byte(), rand_byte());   // blocked by level in service
        send_access(OP_WRITE,  1'b0, 8'h20, rand_byte());         // non-specific EOI
        send_access(OP_ACK,    1'b0, rand_byte(), rand_byte());
        send_access(OP_WRITE,  1'b0, 8'h61, rand_byte());         // specific EOI on level 1
        send_access(OP_WRITE,  1'b1, 8'hFF, rand_byte());         // mask every line
        send_access(OP_ACK,    1'b0, rand_byte(), rand_byte());
        send_access(OP_READ,   1'b1, rand_byte(), rand_byte());
        send_access(OP_WRITE,  1'b0, 8'h0A, rand_byte());         // select IRR
        send_access(OP_READ,   1'b0, rand_byte(), rand_byte());
        send_access(OP_WRITE,  1'b0, 8'h80, rand_byte());         // OCW2 without EOI
        send_access(OP_WRITE,  1'b0, 8'h18, rand_byte());         // level, cascade, no ICW4
        send_access(OP_WRITE,  1'b1, 8'h00, rand_byte());
        send_access(OP_WRITE,  1'b1, 8'h5A, rand_byte());         // ICW3, ignored
        send_access(OP_WRITE,  1'b1, 8'h00, rand_byte());
        send_access(OP_SAMPLE, 1'b0, rand_byte(), 8'h80);
        send_access(OP_WRITE,  1'b0, 8'h13, rand_byte());
        send_access(OP_WRITE,  1'b1, 8'h40, rand_byte());
        send_access(OP_WRITE,  1'b1, 8'h03, rand_byte());         // auto-EOI
        send_access(OP_ACK,    1'b0, rand_byte(), rand_byte());
        send_access(OP_READ,   1'b0, rand_byte(), rand_byte());

        // Random accesses at full rate, with one long receiver hold-off midway
        run_random_accesses(100);
        hold_off_len = 40;
        hold_off_requests++;
        run_random_accesses(100);
        wait_for_responses();

        set_idling(46, 0);
        run_random_accesses(200);
        wait_for_responses();

        set_idling(0, 46);
        run_random_accesses(200);
        wait_for_responses();

        set_idling(14, 14);
        run_random_accesses(200);
        wait_for_responses();

        // Catch any stray response after the last one expected
        repeat (10) @(posedge aclk);
        if (model.errors == 0 && model.outstanding() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/core/pic_pkg.sv
rtl/core/pic_in_stage.sv
rtl/core/pic_core.sv
rtl/core/programmable_interrupt_controller_unit.sv
rtl/core/pic_checker.sv
sim/tb_programmable_interrupt_controller_unit.sv
